// File: rtl/core/ems_pkg.sv
// Shared types, widths and codes of the ellipse mask score sum block.
// Used by every module under rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package ems_pkg;

  // Default grid size of the map store.
  localparam int GRID_ROWS_DEF = 128;
  localparam int GRID_COLS_DEF = 128;

  // Field widths.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int ORG_W      = 12;   // min_row, min_col
  localparam int USE_W      = 8;    // rows_in_use, cols_in_use
  localparam int PIX_W      = 7;    // pixel_row, pixel_col
  localparam int LL_W       = 16;   // fore_ll, back_ll
  localparam int CTR_W      = 16;   // centre_x, centre_y (Q12.4)
  localparam int RAD_W      = 12;   // radius_x, radius_y (Q8.4)
  localparam int DIFF_W     = 17;   // map entry, Q9.8
  localparam int SUM_W      = 32;

  // Internal widths of the walk.
  localparam int POS_W  = 14;       // integer pixel coordinate
  localparam int BND_W  = 18;       // Q.4 bound before the floor
  localparam int DEL_W  = 19;       // signed Q.4 offset from the centre
  localparam int MAG_W  = 13;       // magnitude of that offset
  localparam int GRD_W  = 15;       // grid coordinate, signed
  localparam int EFF_W  = 11;       // rows or columns in use after the clamp
  localparam int MUL_W  = 25;       // operand of the shared multiplier
  localparam int PROD_W = 2 * MUL_W;
  localparam int RSQ_W  = 24;       // radius squared
  localparam int LIM_W  = 48;       // rx^2 * ry^2

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ROW     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_COL     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 2'd3;

  localparam logic [USE_W-1:0] USE_RST = 8'd128;

  // Operation codes of an input beat.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic signed [ORG_W-1:0] min_row;
    logic signed [ORG_W-1:0] min_col;
    logic [USE_W-1:0]        rows_in_use;
    logic [USE_W-1:0]        cols_in_use;
  } grid_cfg_t;

  typedef struct packed {
    logic signed [CTR_W-1:0] cx;
    logic signed [CTR_W-1:0] cy;
    logic [RAD_W-1:0]        rx;
    logic [RAD_W-1:0]        ry;
  } query_t;

  typedef struct packed {
    logic start;   // a query beat is accepted
    logic take;    // the finished result moves to the output register
  } walk_ctl_t;

  typedef struct packed {
    logic busy;    // a query is in work or its result is waiting
    logic done;    // the result is ready
  } walk_sts_t;

  function automatic int addr_width(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

// File: rtl/core/ems_mul.sv
// Shared unsigned multiplier of the ellipse walk, product registered.
// Depends on ems_pkg for the operand width.
`timescale 1ns / 1ps

module ems_mul (
  input  logic                      clk,
  input  logic [ems_pkg::MUL_W-1:0]  a,
  input  logic [ems_pkg::MUL_W-1:0]  b,
  output logic [ems_pkg::PROD_W-1:0] p
);
  import ems_pkg::*;

  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

// File: rtl/core/ems_map.sv
// Map store of per-pixel score differences: one write port, one read port.
// Read data is registered. Depends on ems_pkg for the entry width.
`timescale 1ns / 1ps

module ems_map #(
  parameter int DEPTH = ems_pkg::GRID_ROWS_DEF * ems_pkg::GRID_COLS_DEF,
  parameter int AW    = ems_pkg::addr_width(DEPTH)
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [AW-1:0]                     wr_addr,
  input  logic signed [ems_pkg::DIFF_W-1:0] wr_data,
  input  logic                              rd_en,
  input  logic [AW-1:0]                     rd_addr,
  output logic signed [ems_pkg::DIFF_W-1:0] rd_data
);
  import ems_pkg::*;

  logic signed [DIFF_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/ems_walk.sv
// Sequencer that walks the bounding box of one ellipse, tests each pixel on
// the shared multiplier and accumulates the map values. Depends on ems_pkg
// and ems_mul; reads the map store through its own read port.
`timescale 1ns / 1ps

module ems_walk #(
  parameter int GRID_ROWS = ems_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS = ems_pkg::GRID_COLS_DEF,
  parameter int AW        = ems_pkg::addr_width(GRID_ROWS * GRID_COLS)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ems_pkg::walk_ctl_t                ctl,
  input  ems_pkg::query_t                   query,
  input  ems_pkg::grid_cfg_t                cfg,
  output ems_pkg::walk_sts_t                sts,
  output logic signed [ems_pkg::SUM_W-1:0]  sum,
  output logic                              clip,
  output logic                              rd_en,
  output logic [AW-1:0]                     rd_addr,
  input  logic signed [ems_pkg::DIFF_W-1:0] rd_data
);
  import ems_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RX2  = 4'd1;
  localparam logic [3:0] S_RY2  = 4'd2;
  localparam logic [3:0] S_LIM  = 4'd3;
  localparam logic [3:0] S_LIMW = 4'd4;
  localparam logic [3:0] S_COL  = 4'd5;
  localparam logic [3:0] S_XT   = 4'd6;
  localparam logic [3:0] S_XCHK = 4'd7;
  localparam logic [3:0] S_DY2  = 4'd8;
  localparam logic [3:0] S_YT   = 4'd9;
  localparam logic [3:0] S_YCHK = 4'd10;
  localparam logic [3:0] S_ACC  = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  localparam logic [EFF_W-1:0] RowsMax = EFF_W'(GRID_ROWS);
  localparam logic [EFF_W-1:0] ColsMax = EFF_W'(GRID_COLS);
  localparam logic signed [SUM_W-1:0] SumMax = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SumMin = {1'b1, {(SUM_W-1){1'b0}}};

  logic [3:0] state;

  query_t                  q;
  logic signed [POS_W-1:0] left, right, top_y, bot_y;
  logic signed [POS_W-1:0] x, y;
  logic [RSQ_W-1:0]        rx2, ry2;
  logic [LIM_W-1:0]        lim;
  logic [PROD_W-1:0]       xt;
  logic                    in_grid;
  logic [AW-1:0]           addr;

  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;

  logic [BND_W-1:0] lo_x, hi_x, lo_y, hi_y;
  logic [DEL_W-1:0] dx, dy;
  logic [MAG_W-1:0] adx, ady;
  logic [GRD_W-1:0] gx, gy;
  logic [EFF_W-1:0] rows_eff, cols_eff;
  logic             in_grid_next;
  logic [AW-1:0]    addr_next;
  logic [PROD_W:0]  test_sum;
  logic             hit;
  logic [SUM_W:0]   acc_wide;
  logic signed [SUM_W-1:0] sum_next;

  ems_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Bounding box: floor(c - r) .. floor(c + r + 15) in Q.4, shifted down.
  always_comb begin
    lo_x = {{2{query.cx[CTR_W-1]}}, query.cx} - BND_W'(query.rx);
    hi_x = {{2{query.cx[CTR_W-1]}}, query.cx} + BND_W'(query.rx) + BND_W'(15);
    lo_y = {{2{query.cy[CTR_W-1]}}, query.cy} - BND_W'(query.ry);
    hi_y = {{2{query.cy[CTR_W-1]}}, query.cy} + BND_W'(query.ry) + BND_W'(15);
  end

  // Offsets from the centre and the grid position of the current pixel.
  always_comb begin
    dx  = {x[POS_W-1], x, 4'b0000} - {{3{q.cx[CTR_W-1]}}, q.cx};
    dy  = {y[POS_W-1], y, 4'b0000} - {{3{q.cy[CTR_W-1]}}, q.cy};
    adx = dx[DEL_W-1] ? MAG_W'(-dx) : dx[MAG_W-1:0];
    ady = dy[DEL_W-1] ? MAG_W'(-dy) : dy[MAG_W-1:0];

    gx = {x[POS_W-1], x} - {{3{cfg.min_col[ORG_W-1]}}, cfg.min_col};
    gy = {y[POS_W-1], y} - {{3{cfg.min_row[ORG_W-1]}}, cfg.min_row};
    rows_eff = (EFF_W'(cfg.rows_in_use) < RowsMax) ? EFF_W'(cfg.rows_in_use) : RowsMax;
    cols_eff = (EFF_W'(cfg.cols_in_use) < ColsMax) ? EFF_W'(cfg.cols_in_use) : ColsMax;
    in_grid_next = !gx[GRD_W-1] && !gy[GRD_W-1] &&
                   (gx[GRD_W-2:0] < (GRD_W-1)'(cols_eff)) &&
                   (gy[GRD_W-2:0] < (GRD_W-1)'(rows_eff));
    addr_next = AW'(AW'(gy[GRD_W-2:0]) * AW'(GRID_COLS) + AW'(gx[GRD_W-2:0]));
  end

  // Operand selection of the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_RX2: begin
        mul_a = MUL_W'(q.rx);
        mul_b = MUL_W'(q.rx);
      end
      S_RY2: begin
        mul_a = MUL_W'(q.ry);
        mul_b = MUL_W'(q.ry);
      end
      S_LIM: begin
        mul_a = MUL_W'(rx2);
        mul_b = prod[MUL_W-1:0];
      end
      S_COL: begin
        mul_a = MUL_W'(adx);
        mul_b = MUL_W'(adx);
      end
      S_XT: begin
        mul_a = prod[MUL_W-1:0];
        mul_b = MUL_W'(ry2);
      end
      S_DY2: begin
        mul_a = MUL_W'(ady);
        mul_b = MUL_W'(ady);
      end
      S_YT: begin
        mul_a = prod[MUL_W-1:0];
        mul_b = MUL_W'(rx2);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    test_sum = {1'b0, xt} + {1'b0, prod};
    hit      = test_sum <= (PROD_W+1)'(lim);
    acc_wide = {sum[SUM_W-1], sum} + {{(SUM_W+1-DIFF_W){rd_data[DIFF_W-1]}}, rd_data};
    if (acc_wide[SUM_W] != acc_wide[SUM_W-1]) begin
      sum_next = acc_wide[SUM_W] ? SumMin : SumMax;
    end else begin
      sum_next = acc_wide[SUM_W-1:0];
    end
  end

  assign rd_en   = (state == S_YCHK) && hit && in_grid;
  assign rd_addr = addr;
  assign sts.busy = (state != S_IDLE);
  assign sts.done = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (ctl.start) begin
            q     <= query;
            left  <= lo_x[BND_W-1:4];
            right <= hi_x[BND_W-1:4];
            top_y <= lo_y[BND_W-1:4];
            bot_y <= hi_y[BND_W-1:4];
            sum   <= '0;
            clip  <= 1'b0;
            if (query.rx == '0 || query.ry == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_RX2;
            end
          end
        end
        S_RX2: state <= S_RY2;
        S_RY2: begin
          rx2   <= prod[RSQ_W-1:0];
          state <= S_LIM;
        end
        S_LIM: begin
          ry2   <= prod[RSQ_W-1:0];
          state <= S_LIMW;
        end
        S_LIMW: begin
          lim   <= prod[LIM_W-1:0];
          x     <= left;
          state <= S_COL;
        end
        S_COL: state <= S_XT;
        S_XT:  state <= S_XCHK;
        S_XCHK: begin
          xt <= prod;
          if (prod > PROD_W'(lim)) begin
            // No pixel of this column can be inside.
            if (x == right) begin
              state <= S_DONE;
            end else begin
              x     <= x + POS_W'(1);
              state <= S_COL;
            end
          end else begin
            y     <= top_y;
            state <= S_DY2;
          end
        end
        S_DY2: begin
          in_grid <= in_grid_next;
          addr    <= addr_next;
          state   <= S_YT;
        end
        S_YT: state <= S_YCHK;
        S_YCHK, S_ACC: begin
          if (state == S_YCHK && hit && in_grid) begin
            state <= S_ACC;
          end else begin
            if (state == S_ACC) begin
              sum <= sum_next;
            end else if (hit) begin
              clip <= 1'b1;
            end
            if (y != bot_y) begin
              y     <= y + POS_W'(1);
              state <= S_DY2;
            end else if (x != right) begin
              x     <= x + POS_W'(1);
              state <= S_COL;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (ctl.take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_zero_radius: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && ctl.start && (query.rx == '0 || query.ry == '0))
    |=> (state == S_DONE && sum == '0 && !clip))
    else $error("zero radius query did not finish empty");

  a_clip_sticky: assert property (@(posedge clk) disable iff (rst)
    (clip && state != S_IDLE) |=> clip)
    else $error("clipped flag dropped during a query");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_COL) |-> (x >= left && x <= right))
    else $error("column left the bounding box");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DY2) |-> (y >= top_y && y <= bot_y))
    else $error("row left the bounding box");

endmodule

// File: rtl/core/ellipse_mask_score_sum_top.sv
// Top level of the ellipse mask score sum block: ports, configuration
// registers, map store, ellipse walk and output register.
// Depends on ems_pkg, ems_map, ems_walk and ems_mul.
//
// Use: the input channel carries one beat per item. A load beat (op = 0)
// writes fore_ll - back_ll into the map at (pixel_row, pixel_col) and gives
// no result. A query beat (op = 1) gives one result beat
// with the saturated sum of the map values inside the ellipse and a flag for
// inside pixels that fell outside the grid in use.
// A query forms rx^2, ry^2 and the limit rx^2 * ry^2, then for each column of
// the bounding box the x term, and for each pixel of a column that touches the
// ellipse the y term, reading the map for each pixel summed; a zero radius goes
// straight to the hand-over. The single multiplier forms every square and product.
// A bounding box spans at most 514 by 514 pixels.
// in_stall is high from the acceptance of a query until its result is moved
// to the output register; a stalled output holds its beat and blocks the
// hand-over of the next query result and, while that result waits, the acceptance of loads.
// Configuration writes are always ready and are meant for idle periods.
// Reset restores the register defaults and empties both channels; the map
// contents are undefined until loaded.
`timescale 1ns / 1ps

module ellipse_mask_score_sum_top #(
  parameter int GRID_ROWS = ems_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS = ems_pkg::GRID_COLS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Input channel.
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  op,
  input  logic [ems_pkg::PIX_W-1:0]             pixel_row,
  input  logic [ems_pkg::PIX_W-1:0]             pixel_col,
  input  logic signed [ems_pkg::LL_W-1:0]       fore_ll,
  input  logic signed [ems_pkg::LL_W-1:0]       back_ll,
  input  logic signed [ems_pkg::CTR_W-1:0]      centre_x,
  input  logic signed [ems_pkg::CTR_W-1:0]      centre_y,
  input  logic [ems_pkg::RAD_W-1:0]             radius_x,
  input  logic [ems_pkg::RAD_W-1:0]             radius_y,
  // Result channel.
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [ems_pkg::SUM_W-1:0]      score_sum,
  output logic                                  clipped,
  // Configuration channel.
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ems_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ems_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import ems_pkg::*;

  localparam int Depth = GRID_ROWS * GRID_COLS;
  localparam int AW    = addr_width(Depth);

  grid_cfg_t cfg;
  query_t    query;
  walk_ctl_t ctl;
  walk_sts_t sts;

  logic                     accept;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic signed [DIFF_W-1:0] wr_data;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic signed [DIFF_W-1:0] rd_data;
  logic signed [SUM_W-1:0]  walk_sum;
  logic                     walk_clip;

  // Configuration registers; the port never pushes back.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_row     <= '0;
      cfg.min_col     <= '0;
      cfg.rows_in_use <= USE_RST;
      cfg.cols_in_use <= USE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_ROW:     cfg.min_row     <= cfg_data;
        CFG_MIN_COL:     cfg.min_col     <= cfg_data;
        CFG_ROWS_IN_USE: cfg.rows_in_use <= cfg_data[USE_W-1:0];
        CFG_COLS_IN_USE: cfg.cols_in_use <= cfg_data[USE_W-1:0];
        default: ;
      endcase
    end
  end

  // The input side is held off for the whole of a query, including the wait
  // for the output register.
  assign in_stall = sts.busy;
  assign accept   = in_valid && !in_stall;

  // Loads go straight into the map; beats outside the grid are dropped.
  assign wr_en   = accept && (op == OP_LOAD) &&
                   (int'(pixel_row) < GRID_ROWS) && (int'(pixel_col) < GRID_COLS);
  assign wr_addr = AW'(AW'(pixel_row) * AW'(GRID_COLS) + AW'(pixel_col));
  assign wr_data = {fore_ll[LL_W-1], fore_ll} - {back_ll[LL_W-1], back_ll};

  assign query.cx = centre_x;
  assign query.cy = centre_y;
  assign query.rx = radius_x;
  assign query.ry = radius_y;

  // A finished result moves over as soon as the output register is free or
  // being emptied in the same cycle.
  assign ctl.start = accept && (op == OP_QUERY);
  assign ctl.take  = sts.done && (!out_valid || !out_stall);

  ems_map #(
    .DEPTH (Depth),
    .AW    (AW)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ems_walk #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS),
    .AW        (AW)
  ) u_walk (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .query   (query),
    .cfg     (cfg),
    .sts     (sts),
    .sum     (walk_sum),
    .clip    (walk_clip),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.take) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      score_sum <= walk_sum;
      clipped   <= walk_clip;
    end
  end

endmodule
